@@ rtl/core/mftsm_pkg.sv @@
// Shared types and constants of the mixed-oxide fuel thermal strain block.
`default_nettype none
package mftsm_pkg;

    localparam int TAG_W   = 20;
    localparam int TEMP_W  = 16;
    localparam int IN_DW   = 32;
    localparam int COEF_W  = 40;
    localparam int TC_W    = 29;
    localparam int SQ_W    = 57;
    localparam int CU_W    = 54;
    localparam int ACC_W   = 112;
    localparam int P_W     = 64;
    localparam int DIFF_W  = 65;
    localparam int S_W     = 60;
    localparam int FRAC_W  = 16;
    localparam int REG_N   = 8;
    localparam int REG_IDX_W = 3;

    localparam int PU_MASS_NUM = 100;
    localparam int PU_MASS_DEN = 113;

    // 273.15 K in Q16
    localparam logic signed [TC_W-1:0] CELSIUS_OFFSET = 29'sd17901158;
    // 1e-7 in units of 2^-40
    localparam logic signed [COEF_W-1:0] SMALL_LIMIT = 40'sd109951;
    localparam logic signed [COEF_W-1:0] SAT_HIGH = 40'sh7F_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] SAT_LOW  = 40'sh80_0000_0000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PUO2_C0 = 3'd0,
        REG_PUO2_C1 = 3'd1,
        REG_PUO2_C2 = 3'd2,
        REG_PUO2_C3 = 3'd3,
        REG_UO2_C0  = 3'd4,
        REG_UO2_C1  = 3'd5,
        REG_UO2_C2  = 3'd6,
        REG_UO2_C3  = 3'd7
    } t_reg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_RESET [REG_N] = '{
        -40'sd436890945, 40'sd9340901, 40'sd155017502, 40'sd449031310,
        -40'sd546677182, 40'sd7814228, 40'sd185980650, 40'sd137817541000
    };

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage
`default_nettype wire

@@ rtl/core/mox_fuel_thermal_strain.sv @@
// Top level of the mixed-oxide fuel thermal strain pipeline.
`default_nettype none
// Computes the linear thermal strain of one mesh cell of mixed uranium-plutonium
// oxide fuel per request. A request is taken at every clock edge where start is
// high and busy is low; busy is only high during reset, so one request per cycle
// is accepted without gaps. Each request yields exactly one result, in request
// order: it passes the input register, the division chain and then the rounding,
// blend and output registers, and o_valid marks the result when it is shown.
// The latency is set by the division chain that forms the plutonium fraction:
// one cell per quotient bit (FRACTION_BITS + 1 cells) behind the input register,
// followed by the blend multiplier, rounding and saturation stages. The
// polynomial side (Celsius conversion, square, cube, two cubic polynomials)
// runs alongside and is delayed to meet it. The receiver cannot stall: take
// every result in the cycle it is shown. Write coefficients through
// i_cfg_we/i_cfg_idx/i_cfg_data only while no request is in flight. A zero
// density sum reports sum_error with zero strain and zero mass fraction.
module mox_fuel_thermal_strain
    import mftsm_pkg::*;
#(
    parameter int DENSITY_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [TAG_W-1:0]       i_cell_tag,
    input  wire logic [TEMP_W-1:0]      i_temp_kelvin,
    input  wire logic [IN_DW-1:0]       i_dens_uranium,
    input  wire logic [IN_DW-1:0]       i_dens_plutonium,
    input  wire logic [IN_DW-1:0]       i_dens_americium,
    input  wire logic [IN_DW-1:0]       i_dens_neptunium,
    input  wire logic                   i_cfg_we,
    input  wire logic [REG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [COEF_W-1:0]      i_cfg_data,
    output logic                        o_valid,
    output logic [TAG_W-1:0]            o_cell_tag_out,
    output logic signed [COEF_W-1:0]    o_strain,
    output logic [FRAC_W-1:0]           o_pu_mass_frac,
    output logic                        o_strain_zeroed,
    output logic                        o_sum_error
);
    localparam int DW    = DENSITY_WIDTH;
    localparam int SUM_W = DW + 2;
    localparam int DEN_W = DW + 9;
    localparam int Q_W   = FRACTION_BITS + 1;
    localparam int W_W   = FRACTION_BITS + 1;
    localparam int DLY   = FRACTION_BITS - 7;
    localparam int BL_W  = W_W + 1 + DIFF_W;
    localparam int ACC2_W = P_W + FRACTION_BITS + 4;

    // coefficient registers
    t_coef r_coef [REG_N];

    // density front end
    logic [DW-1:0]    nu, npu, nam, nnp;
    logic [SUM_W-1:0] n_sum;
    logic             accept;

    // division chain
    t_ctl             c_ctl [Q_W+1];
    logic [TAG_W-1:0] c_tag [Q_W+1];
    logic [DEN_W-1:0] c_den [Q_W+1];
    logic [DEN_W:0]   c_rem [Q_W+1];
    logic [Q_W-1:0]   c_q   [Q_W+1];

    // polynomial side
    logic signed [TC_W-1:0]      r_tc1, r_tc2, r_tc3, r_tc4, r_tc5;
    logic signed [SQ_W-1:0]      r_sq2, r_sq3, r_sq4, r_sq5;
    logic signed [TC_W+SQ_W-1:0] p_cu, n_cu;
    logic signed [CU_W-1:0]      r_cu5;
    logic signed [P_W-1:0]       p_pu, p_u, r_pu10, r_pu4, r_pu5;
    logic signed [DIFF_W-1:0]    r_diff10;
    logic signed [DIFF_W-1:0]    r_diff_d [DLY];
    logic signed [P_W-1:0]       r_pu_d   [DLY];

    // blend and output side
    logic [Q_W:0]             q_inc;
    t_ctl                     r_ctl3, r_ctl4, r_ctl5, r_ctl6;
    logic [TAG_W-1:0]         r_tag3, r_tag4, r_tag5, r_tag6;
    logic [W_W-1:0]           r_w3, r_w4, r_w5, r_w6;
    logic signed [BL_W-1:0]   p_blend;
    logic signed [ACC2_W-1:0] n_acc;
    logic signed [S_W-1:0]    r_s6;
    logic                     near_zero, ovf;
    logic [W_W+FRAC_W-1:0]    w_ext;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // keep each density modulo 2^DENSITY_WIDTH
    assign nu  = DW'(i_dens_uranium);
    assign npu = DW'(i_dens_plutonium);
    assign nam = DW'(i_dens_americium);
    assign nnp = DW'(i_dens_neptunium);
    assign n_sum = SUM_W'(nu) + SUM_W'(npu) + SUM_W'(nam) + SUM_W'(nnp);

    // stage 1: load the head of the division chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0] <= '0;
        end else begin
            c_ctl[0] <= '{valid: accept, zero: (n_sum == '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        c_tag[0] <= i_cell_tag;
        c_den[0] <= DEN_W'(n_sum) * DEN_W'(PU_MASS_DEN);
        c_rem[0] <= (DEN_W+1)'(npu) * (DEN_W+1)'(PU_MASS_NUM);
        c_q[0]   <= '0;
        r_tc1    <= $signed({1'b0, i_temp_kelvin, 12'b0}) - CELSIUS_OFFSET;
    end

    // one cell per quotient bit
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        mftsm_div_cell #(.DEN_W(DEN_W), .Q_W(Q_W)) u_cell (
            .i_clk, .i_rst_n,
            .i_ctl(c_ctl[k]), .i_tag(c_tag[k]), .i_den(c_den[k]),
            .i_rem(c_rem[k]), .i_q(c_q[k]),
            .o_ctl(c_ctl[k+1]), .o_tag(c_tag[k+1]), .o_den(c_den[k+1]),
            .o_rem(c_rem[k+1]), .o_q(c_q[k+1])
        );
    end

    // square, then cube rounded to Q16
    mftsm_mul #(.AW(TC_W), .BW(SQ_W)) u_cube (
        .i_clk, .i_a(r_tc2), .i_b(r_sq2), .o_p(p_cu)
    );
    assign n_cu = p_cu + ((TC_W+SQ_W)'(1) << 31);

    always_ff @(posedge i_clk) begin
        r_sq2 <= r_tc1 * r_tc1;
        r_tc2 <= r_tc1;
        r_tc3 <= r_tc2;
        r_tc4 <= r_tc3;
        r_tc5 <= r_tc4;
        r_sq3 <= r_sq2;
        r_sq4 <= r_sq3;
        r_sq5 <= r_sq4;
        r_cu5 <= n_cu[32+CU_W-1:32];
    end

    mftsm_poly u_poly_pu (
        .i_clk,
        .i_c0(r_coef[REG_PUO2_C0]), .i_c1(r_coef[REG_PUO2_C1]),
        .i_c2(r_coef[REG_PUO2_C2]), .i_c3(r_coef[REG_PUO2_C3]),
        .i_tc(r_tc5), .i_sq(r_sq5), .i_cu(r_cu5), .o_p(p_pu)
    );

    mftsm_poly u_poly_u (
        .i_clk,
        .i_c0(r_coef[REG_UO2_C0]), .i_c1(r_coef[REG_UO2_C1]),
        .i_c2(r_coef[REG_UO2_C2]), .i_c3(r_coef[REG_UO2_C3]),
        .i_tc(r_tc5), .i_sq(r_sq5), .i_cu(r_cu5), .o_p(p_u)
    );

    // hold the polynomial results until the quotient is ready
    always_ff @(posedge i_clk) begin
        r_diff10    <= {p_pu[P_W-1], p_pu} - {p_u[P_W-1], p_u};
        r_pu10      <= p_u;
        r_diff_d[0] <= r_diff10;
        r_pu_d[0]   <= r_pu10;
        for (int i = 1; i < DLY; i++) begin
            r_diff_d[i] <= r_diff_d[i-1];
            r_pu_d[i]   <= r_pu_d[i-1];
        end
        r_pu4 <= r_pu_d[DLY-1];
        r_pu5 <= r_pu4;
    end

    // round the quotient to the mass fraction
    assign q_inc = {1'b0, c_q[Q_W]} + (Q_W+1)'(1);

    mftsm_mul #(.AW(W_W+1), .BW(DIFF_W)) u_blend (
        .i_clk, .i_a($signed({1'b0, r_w3})), .i_b(r_diff_d[DLY-1]), .o_p(p_blend)
    );

    assign n_acc = {{4{r_pu5[P_W-1]}}, r_pu5, {FRACTION_BITS{1'b0}}}
                 + {p_blend[BL_W-1], p_blend}
                 + (ACC2_W'(1) << (FRACTION_BITS + 7));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctl6 <= '0;
        end else begin
            r_ctl3 <= c_ctl[Q_W];
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
            r_ctl6 <= r_ctl5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag3 <= c_tag[Q_W];
        r_tag4 <= r_tag3;
        r_tag5 <= r_tag4;
        r_tag6 <= r_tag5;
        r_w3   <= q_inc[Q_W:1];
        r_w4   <= r_w3;
        r_w5   <= r_w4;
        r_w6   <= r_w5;
        r_s6   <= n_acc[ACC2_W-1:FRACTION_BITS+8];
    end

    // drop small strain to zero, clamp large strain to 40 bits
    assign near_zero = (r_s6 >= -SMALL_LIMIT) && (r_s6 <= SMALL_LIMIT);
    assign ovf   = (r_s6[S_W-1:COEF_W-1] != {(S_W-COEF_W+1){r_s6[S_W-1]}});
    assign w_ext = {{FRAC_W{1'b0}}, r_w6};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_ctl6.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_cell_tag_out <= r_tag6;
        o_sum_error    <= r_ctl6.zero;
        if (r_ctl6.zero) begin
            o_strain        <= '0;
            o_pu_mass_frac  <= '0;
            o_strain_zeroed <= 1'b0;
        end else begin
            o_pu_mass_frac  <= w_ext[FRAC_W-1:0];
            o_strain_zeroed <= near_zero;
            if (near_zero) begin
                o_strain <= '0;
            end else if (ovf) begin
                o_strain <= r_s6[S_W-1] ? SAT_LOW : SAT_HIGH;
            end else begin
                o_strain <= r_s6[COEF_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/mftsm_mul.sv @@
// Two-stage signed multiplier built from two half-width partial products.
`default_nettype none
module mftsm_mul #(
    parameter int AW = 40,
    parameter int BW = 29
) (
    input  wire logic                  i_clk,
    input  wire logic signed [AW-1:0]  i_a,
    input  wire logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0]    o_p
);
    localparam int LO = BW / 2;
    localparam int HI = BW - LO;

    logic signed [AW+LO:0]   n_plo, r_plo;
    logic signed [AW+HI-1:0] n_phi, r_phi;
    logic signed [AW+BW-1:0] hi_ext, lo_ext;

    assign n_plo = i_a * $signed({1'b0, i_b[LO-1:0]});
    assign n_phi = i_a * $signed(i_b[BW-1:LO]);
    assign hi_ext = {r_phi, {LO{1'b0}}};
    assign lo_ext = {{(BW-LO-1){r_plo[AW+LO]}}, r_plo};

    always_ff @(posedge i_clk) begin
        r_plo <= n_plo;
        r_phi <= n_phi;
        o_p   <= hi_ext + lo_ext;
    end
endmodule
`default_nettype wire

@@ rtl/core/mftsm_div_cell.sv @@
// One restoring-division cell: produce one quotient bit and pass the rest on.
`default_nettype none
module mftsm_div_cell
    import mftsm_pkg::*;
#(
    parameter int DEN_W = 41,
    parameter int Q_W   = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [DEN_W:0]    i_rem,
    input  wire logic [Q_W-1:0]    i_q,
    output t_ctl                   o_ctl,
    output logic [TAG_W-1:0]       o_tag,
    output logic [DEN_W-1:0]       o_den,
    output logic [DEN_W:0]         o_rem,
    output logic [Q_W-1:0]         o_q
);
    logic [DEN_W:0] rem2;
    logic           fits;

    assign rem2 = {i_rem[DEN_W-1:0], 1'b0};
    assign fits = rem2 >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_tag <= i_tag;
        o_den <= i_den;
        o_rem <= fits ? rem2 - {1'b0, i_den} : rem2;
        o_q   <= {i_q[Q_W-2:0], fits};
    end
endmodule
`default_nettype wire

@@ rtl/core/mftsm_poly.sv @@
// Cubic strain polynomial: three products, pairwise sums, final round to 2^-48.
`default_nettype none
module mftsm_poly
    import mftsm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic signed [COEF_W-1:0] i_c0,
    input  wire logic signed [COEF_W-1:0] i_c1,
    input  wire logic signed [COEF_W-1:0] i_c2,
    input  wire logic signed [COEF_W-1:0] i_c3,
    input  wire logic signed [TC_W-1:0]   i_tc,
    input  wire logic signed [SQ_W-1:0]   i_sq,
    input  wire logic signed [CU_W-1:0]   i_cu,
    output logic signed [P_W-1:0]         o_p
);
    logic signed [COEF_W+TC_W-1:0] p1;
    logic signed [COEF_W+SQ_W-1:0] p2;
    logic signed [COEF_W+CU_W-1:0] p3;
    logic signed [ACC_W-1:0]       t0, t1, t2, t3, r_a, r_b, n_sum;

    mftsm_mul #(.AW(COEF_W), .BW(TC_W)) u_m1 (.i_clk, .i_a(i_c1), .i_b(i_tc), .o_p(p1));
    mftsm_mul #(.AW(COEF_W), .BW(SQ_W)) u_m2 (.i_clk, .i_a(i_c2), .i_b(i_sq), .o_p(p2));
    mftsm_mul #(.AW(COEF_W), .BW(CU_W)) u_m3 (.i_clk, .i_a(i_c3), .i_b(i_cu), .o_p(p3));

    // align every term at 2^-96
    assign t0 = {{16{i_c0[COEF_W-1]}}, i_c0, 56'b0};
    assign t1 = {{3{p1[COEF_W+TC_W-1]}}, p1, 40'b0};
    assign t2 = {{7{p2[COEF_W+SQ_W-1]}}, p2, 8'b0};
    assign t3 = {{18{p3[COEF_W+CU_W-1]}}, p3};
    assign n_sum = r_a + r_b + (ACC_W'(1) << 47);

    always_ff @(posedge i_clk) begin
        r_a <= t0 + t1;
        r_b <= t2 + t3;
        o_p <= n_sum[ACC_W-1:48];
    end
endmodule
`default_nettype wire

@@ rtl/core/mftsm_checker.sv @@
// Port-level checks of the thermal strain block, bound to the top level.
`default_nettype none
module mftsm_checker
    import mftsm_pkg::*;
#(
    parameter int LATENCY = 23
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic                    o_valid,
    input wire logic signed [COEF_W-1:0] o_strain,
    input wire logic [FRAC_W-1:0]       o_pu_mass_frac,
    input wire logic                    o_strain_zeroed,
    input wire logic                    o_sum_error
);
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result without request");

    a_sum_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sum_error |-> o_strain == '0 && o_pu_mass_frac == '0
            && !o_strain_zeroed)
        else $error("zero density sum result not cleared");

    a_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_strain_zeroed |-> o_strain == '0 && !o_sum_error)
        else $error("zeroed strain not zero");
endmodule

bind mox_fuel_thermal_strain mftsm_checker #(.LATENCY(FRACTION_BITS + 7)) u_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_strain, .o_pu_mass_frac,
    .o_strain_zeroed, .o_sum_error
);
`default_nettype wire

@@ dv/tb_mox_fuel_thermal_strain.sv @@
// Self-checking testbench for the mixed-oxide fuel thermal strain pipeline.
`default_nettype none

module tb_mox_fuel_thermal_strain;
    import mftsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 16 + 7;

    typedef struct {
        logic [TAG_W-1:0]         tag;
        logic signed [COEF_W-1:0] strain;
        logic [FRAC_W-1:0]        frac;
        logic                     zeroed;
        logic                     sum_err;
    } t_cell_res;

    // Predicts the strain of each request and holds the results still due.
    class strain_scoreboard;
        t_coef     coef [REG_N];
        t_cell_res due_q [$];
        int        n_checked;
        int        n_errors;
        int        n_zeroed;
        int        n_sumerr;
        int        n_sat;

        function new();
            for (int i = 0; i < REG_N; i++) coef[i] = COEF_RESET[i];
            n_checked = 0;
            n_errors  = 0;
            n_zeroed  = 0;
            n_sumerr  = 0;
            n_sat     = 0;
        endfunction

        function void set_coef(t_reg_idx idx, logic [COEF_W-1:0] v);
            coef[idx] = signed'(v);
        endfunction

        // floor(a / 2^n + 1/2), low 64 bits kept as a signed value
        function logic signed [127:0] round_shift(logic signed [127:0] a, int n);
            logic signed [127:0] t;
            t = (a + (128'sd1 <<< (n - 1))) >>> n;
            return $signed(t[63:0]);
        endfunction

        // Cubic in Celsius, result in units of 2^-48
        function logic signed [127:0] cubic(int base, logic signed [127:0] tc,
                                            logic signed [127:0] sq,
                                            logic signed [127:0] cu);
            logic signed [127:0] c0, c1, c2, c3, acc;
            c0  = coef[base];
            c1  = coef[base+1];
            c2  = coef[base+2];
            c3  = coef[base+3];
            acc = (c0 <<< 56) + ((c1 * tc) <<< 40) + ((c2 * sq) <<< 8) + c3 * cu;
            return round_shift(acc, 48);
        endfunction

        function void note(logic [TAG_W-1:0] tag, logic [TEMP_W-1:0] temp,
                           logic [IN_DW-1:0] du, logic [IN_DW-1:0] dp,
                           logic [IN_DW-1:0] da, logic [IN_DW-1:0] dn);
            t_cell_res r;
            logic [63:0] sum, den, rem;
            logic [16:0] q;
            logic signed [127:0] tc, sq, cu, p_pu, p_u, w, acc, s, hi, lo, lim;
            r.tag     = tag;
            r.strain  = '0;
            r.frac    = '0;
            r.zeroed  = 1'b0;
            r.sum_err = 1'b0;
            sum = 64'(du) + 64'(dp) + 64'(da) + 64'(dn);
            if (sum == 0) begin
                r.sum_err = 1'b1;
                n_sumerr++;
                due_q.push_back(r);
                return;
            end
            // plutonium mass fraction by restoring division, one extra bit to round
            den = sum * 113;
            rem = 64'(dp) * 100;
            q   = '0;
            for (int i = 0; i <= 16; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den) begin
                    rem  = rem - den;
                    q[0] = 1'b1;
                end
            end
            w = 128'((18'(q) + 18'd1) >> 1);

            tc = 128'(temp);
            tc = (tc <<< 12) - 128'sd17901158;
            sq = tc * tc;
            cu = round_shift(sq * tc, 32);

            p_pu = cubic(0, tc, sq, cu);
            p_u  = cubic(4, tc, sq, cu);
            acc  = (p_u <<< 16) + w * (p_pu - p_u);
            s    = round_shift(acc, 24);

            lim = SMALL_LIMIT;
            hi  = SAT_HIGH;
            lo  = SAT_LOW;
            if (s >= -lim && s <= lim) begin
                s = 0;
                r.zeroed = 1'b1;
                n_zeroed++;
            end
            if (s > hi || s < lo) n_sat++;
            if (s > hi) s = hi;
            if (s < lo) s = lo;
            r.strain = s[COEF_W-1:0];
            r.frac   = w[FRAC_W-1:0];
            due_q.push_back(r);
        endfunction

        function void check(t_cell_res got);
            t_cell_res exp_r;
            if (due_q.size() == 0) begin
                $error("result for cell %0d with no request outstanding", got.tag);
                n_errors++;
                return;
            end
            exp_r = due_q.pop_front();
            n_checked++;
            if (got.tag !== exp_r.tag) begin
                $error("cell_tag_out: expected %0d, got %0d", exp_r.tag, got.tag);
                n_errors++;
            end
            if (got.strain !== exp_r.strain) begin
                $error("strain: expected %0d, got %0d", exp_r.strain, got.strain);
                n_errors++;
            end
            if (got.frac !== exp_r.frac) begin
                $error("pu_mass_frac: expected %0d, got %0d", exp_r.frac, got.frac);
                n_errors++;
            end
            if (got.zeroed !== exp_r.zeroed) begin
                $error("strain_zeroed: expected %0b, got %0b", exp_r.zeroed, got.zeroed);
                n_errors++;
            end
            if (got.sum_err !== exp_r.sum_err) begin
                $error("sum_error: expected %0b, got %0b", exp_r.sum_err, got.sum_err);
                n_errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [TAG_W-1:0]      i_cell_tag = '0;
    logic [TEMP_W-1:0]     i_temp_kelvin = '0;
    logic [IN_DW-1:0]      i_dens_uranium = '0;
    logic [IN_DW-1:0]      i_dens_plutonium = '0;
    logic [IN_DW-1:0]      i_dens_americium = '0;
    logic [IN_DW-1:0]      i_dens_neptunium = '0;
    logic                  i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [COEF_W-1:0]     i_cfg_data = '0;
    logic                  o_valid;
    logic [TAG_W-1:0]      o_cell_tag_out;
    logic signed [COEF_W-1:0] o_strain;
    logic [FRAC_W-1:0]     o_pu_mass_frac;
    logic                  o_strain_zeroed;
    logic                  o_sum_error;

    strain_scoreboard sb = new();
    int n_sent = 0;

    always #1 i_clk = ~i_clk;

    mox_fuel_thermal_strain dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cell_tag       (i_cell_tag),
        .i_temp_kelvin    (i_temp_kelvin),
        .i_dens_uranium   (i_dens_uranium),
        .i_dens_plutonium (i_dens_plutonium),
        .i_dens_americium (i_dens_americium),
        .i_dens_neptunium (i_dens_neptunium),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_cell_tag_out   (o_cell_tag_out),
        .o_strain         (o_strain),
        .o_pu_mass_frac   (o_pu_mass_frac),
        .o_strain_zeroed  (o_strain_zeroed),
        .o_sum_error      (o_sum_error)
    );

    // Note every request the block takes; values read here predate this edge's updates.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note(i_cell_tag, i_temp_kelvin, i_dens_uranium, i_dens_plutonium,
                    i_dens_americium, i_dens_neptunium);
            n_sent++;
        end
    end

    // Results cannot be held off: check each one in the cycle it is shown.
    always @(posedge i_clk) begin
        t_cell_res got;
        if (i_rst_n && o_valid) begin
            got.tag     = o_cell_tag_out;
            got.strain  = o_strain;
            got.frac    = o_pu_mass_frac;
            got.zeroed  = o_strain_zeroed;
            got.sum_err = o_sum_error;
            sb.check(got);
        end
    end

    // Present one request and hold it until the block takes it; return on that edge.
    task automatic send_cell(logic [TEMP_W-1:0] temp, logic [IN_DW-1:0] du,
                             logic [IN_DW-1:0] dp, logic [IN_DW-1:0] da,
                             logic [IN_DW-1:0] dn);
        start            <= 1'b1;
        i_cell_tag       <= TAG_W'($urandom);
        i_temp_kelvin    <= temp;
        i_dens_uranium   <= du;
        i_dens_plutonium <= dp;
        i_dens_americium <= da;
        i_dens_neptunium <= dn;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    // Drop start for a burst of idle cycles.
    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Let the pipeline drain fully before touching the coefficients.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_coef(t_reg_idx idx, logic [COEF_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        sb.set_coef(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [IN_DW-1:0] rand_dens();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return IN_DW'($urandom_range(1, 255));
            2:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TEMP_W-1:0] rand_temp();
        // half the time the physical range of fuel, otherwise anywhere in the field
        if ($urandom_range(0, 1)) return TEMP_W'($urandom_range(4370, 48000));
        return TEMP_W'($urandom);
    endfunction

    task automatic random_cells(int n, bit gaps);
        for (int i = 0; i < n; i++) begin
            send_cell(rand_temp(), rand_dens(), rand_dens(), rand_dens(), rand_dens());
            if (gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 15));
        end
    endtask

    task automatic load_all(logic [COEF_W-1:0] v);
        for (int i = 0; i < REG_N; i++) write_coef(t_reg_idx'(i), v);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero sum, single species, room temperature.
        send_cell('0, '0, '0, '0, '0);
        send_cell('1, '1, '1, '1, '1);
        send_cell('0, 32'd1, '0, '0, '0);
        send_cell('1, '0, 32'd1, '0, '0);
        send_cell(16'd4370, 32'd1000, 32'd250, '0, '0);
        send_cell(16'd4690, 32'd70000, 32'd30000, 32'd10, 32'd5);
        send_cell(16'd32000, '0, '1, '0, '0);
        send_cell(16'd16000, '0, '0, '1, '1);
        send_cell(16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_cell(16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        idle_cycles(7);
        send_cell(16'd24000, 32'd3, 32'd1, '0, '0);

        random_cells(350, 1'b1);

        // All coefficients zero: every strain is forced to zero.
        drain();
        load_all('0);
        for (int i = 0; i < 10; i++) send_cell(rand_temp(), $urandom, $urandom, '0, '0);

        // Largest positive coefficients drive the strain into saturation.
        drain();
        load_all(40'h7F_FFFF_FFFF);
        send_cell('1, '0, '1, '0, '0);
        send_cell('1, '1, '0, '0, '0);
        random_cells(40, 1'b1);

        drain();
        load_all(40'h80_0000_0000);
        send_cell('1, '0, '1, '0, '0);
        send_cell('0, '1, '1, '0, '0);
        random_cells(40, 1'b1);

        // Random coefficients, some at small scale so results stay in range.
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            for (int i = 0; i < REG_N; i++)
                write_coef(t_reg_idx'(i),
                           ph == 0 ? COEF_W'({$urandom, $urandom})
                                   : COEF_W'($signed($urandom) >>> 4));
            random_cells(80, 1'b1);
        end

        // Back to the reset values, then finish streaming back to back.
        drain();
        for (int i = 0; i < REG_N; i++) write_coef(t_reg_idx'(i), COEF_RESET[i]);
        random_cells(300, 1'b1);
        random_cells(150, 1'b0);

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Checked %0d cells under reset, zero, extreme and random coefficients.",
                 sb.n_checked);
        $display("Zeroed strains: %0d, zero density sums: %0d, saturated strains: %0d.",
                 sb.n_zeroed, sb.n_sumerr, sb.n_sat);
        if (sb.n_errors == 0 && sb.n_checked == n_sent) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
